// ===== hdl/hsfd_pkg.sv =====
// Shared types, constants and arithmetic for the humidity sensor frame decoder.
package hsfd_pkg;

  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam logic [7:0]  CrcPoly    = 8'h31;
  localparam logic [15:0] RawFull    = 16'hFFFF;
  localparam logic [14:0] TempMult   = 15'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [14:0] HumMult    = 15'd12500;
  localparam logic [14:0] HumOffset  = 15'd600;
  localparam logic [14:0] HumMax     = 15'd10000;

  typedef struct packed {
    logic [13:0]        humidity_centi;
    logic signed [14:0] temperature_centi;
    logic               hum_crc_bad;
    logic               temp_crc_bad;
    logic               status;
  } hsfd_result_t;

  function automatic logic [7:0] hsfd_crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(mult * raw / 65535): one constant multiply, then one compare and correct
  function automatic logic [14:0] hsfd_scale(input logic [15:0] raw, input logic [14:0] mult);
    logic [30:0] prod;
    logic [14:0] q1;
    logic [16:0] rem;
    prod = 31'(raw) * 31'(mult);
    q1   = prod[30:16];
    rem  = 17'(prod[15:0]) + 17'(q1);
    return q1 + 15'(rem >= 17'(RawFull));
  endfunction

endpackage

// ===== hdl/hsfd_out_buf.sv =====
// Two-entry result buffer: output register plus skid slot.
module hsfd_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hsfd_pkg::hsfd_result_t push_data_i,
  input  logic                 pop_ready_i,
  output logic                 valid_o,
  output hsfd_pkg::hsfd_result_t data_o,
  output logic                 full_o
);
  import hsfd_pkg::*;

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  hsfd_result_t out_data_q, out_data_d;
  hsfd_result_t skid_data_q, skid_data_d;
  logic         out_free;

  assign out_free = !out_valid_q || pop_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;
  assign full_o  = skid_valid_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed while both entries are occupied");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !pop_ready_i) |=> skid_valid_q)
    else $error("stalled result not held in skid slot");

endmodule

// ===== hdl/humidity_sensor_frame_decoder.sv =====
// Top level of the humidity sensor frame decoder: byte sequencing, CRC check, conversion.
//
//  Channel  Dir  Signals                   Carries
//  s_axis   in   tvalid/tready/tdata/tuser one reply byte; tuser marks frame start
//  m_axis   out  tvalid/tready/tdata/tuser one decoded measurement per six-byte reply
//
//  One byte is taken per cycle while s_axis_tready is high; the sixth byte's transfer
//  pushes the result to the output buffer; CRC update and conversion are combinational.
//  Reset: byte position 0, running CRC 0xFF, output buffer empty.
//  s_axis_tready drops only while both the output register and the skid slot hold results.
module humidity_sensor_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  output logic [2:0]  m_axis_tuser    // [0] status, [1] temp_crc_bad, [2] hum_crc_bad
);
  import hsfd_pkg::*;

  localparam logic [2:0] Pos0 = 3'd0;
  localparam logic [2:0] Pos1 = 3'd1;
  localparam logic [2:0] Pos2 = 3'd2;
  localparam logic [2:0] Pos3 = 3'd3;
  localparam logic [2:0] Pos4 = 3'd4;
  localparam logic [2:0] Pos5 = 3'd5;

  logic [2:0]         pos_q, pos_d, pos_cur;
  logic [7:0]         crc_q, crc_d;
  logic [7:0]         hold_q, hold_d;
  logic [15:0]        temp_raw_q, temp_raw_d;
  logic [15:0]        hum_raw_q, hum_raw_d;
  logic               temp_bad_q, temp_bad_d;
  logic signed [14:0] temp_centi_q, temp_centi_d;
  logic               in_xfer;
  logic               push;
  logic               buf_full;
  logic               hum_bad, any_bad;
  logic [14:0]        hum_scaled;
  logic [13:0]        hum_clamped;
  hsfd_result_t       result;
  hsfd_result_t       out_data;

  assign s_axis_tready = !buf_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign pos_cur       = s_axis_tuser[0] ? Pos0 : pos_q;

  assign hum_bad    = (crc_q != s_axis_tdata);
  assign any_bad    = hum_bad || temp_bad_q;
  assign hum_scaled = hsfd_scale(hum_raw_q, HumMult);

  always_comb begin
    if (hum_scaled < HumOffset) begin
      hum_clamped = '0;
    end else if (hum_scaled > HumMax + HumOffset) begin
      hum_clamped = 14'(HumMax);
    end else begin
      hum_clamped = 14'(hum_scaled - HumOffset);
    end
  end

  always_comb begin
    result.status            = any_bad;
    result.temp_crc_bad      = temp_bad_q;
    result.hum_crc_bad       = hum_bad;
    result.temperature_centi = any_bad ? '0 : temp_centi_q;
    result.humidity_centi    = any_bad ? '0 : hum_clamped;
  end

  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    hold_d       = hold_q;
    temp_raw_d   = temp_raw_q;
    hum_raw_d    = hum_raw_q;
    temp_bad_d   = temp_bad_q;
    temp_centi_d = temp_centi_q;
    push         = 1'b0;
    if (in_xfer) begin
      unique case (pos_cur)
        Pos0, Pos3: begin
          crc_d  = hsfd_crc_feed(CrcInit, s_axis_tdata);
          hold_d = s_axis_tdata;
          pos_d  = pos_cur + 3'd1;
        end
        Pos1: begin
          crc_d      = hsfd_crc_feed(crc_q, s_axis_tdata);
          temp_raw_d = {hold_q, s_axis_tdata};
          pos_d      = Pos2;
        end
        Pos2: begin
          temp_bad_d   = (crc_q != s_axis_tdata);
          crc_d        = CrcInit;
          temp_centi_d = hsfd_scale(temp_raw_q, TempMult) - TempOffset;
          pos_d        = Pos3;
        end
        Pos4: begin
          crc_d     = hsfd_crc_feed(crc_q, s_axis_tdata);
          hum_raw_d = {hold_q, s_axis_tdata};
          pos_d     = Pos5;
        end
        default: begin
          push  = 1'b1;
          crc_d = CrcInit;
          pos_d = Pos0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= Pos0;
      crc_q      <= CrcInit;
      hold_q     <= '0;
      temp_raw_q <= '0;
      hum_raw_q  <= '0;
      temp_bad_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      hold_q     <= hold_d;
      temp_raw_q <= temp_raw_d;
      hum_raw_q  <= hum_raw_d;
      temp_bad_q <= temp_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_centi_q <= temp_centi_d;
  end

  hsfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .pop_ready_i (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_data),
    .full_o      (buf_full)
  );

  assign m_axis_tdata = {3'b000, out_data.humidity_centi, out_data.temperature_centi};
  assign m_axis_tuser = {out_data.hum_crc_bad, out_data.temp_crc_bad, out_data.status};

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= Pos5)
    else $error("byte position out of range");

  a_crc_init_at_word_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == Pos0 || pos_q == Pos3) |-> crc_q == CrcInit)
    else $error("running CRC not reinitialized at word start");

  a_push_only_on_sixth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_xfer && pos_cur == Pos5))
    else $error("result produced outside sixth byte transfer");

endmodule
